FILE: design/hms_pkg.sv
// ----------------------------------------------------------------------------
// hms_pkg
// Shared widths, codes and types of the hours:minutes:seconds countdown timer.
// ----------------------------------------------------------------------------
package hms_pkg;

   localparam int HoursWidth   = 7;
   localparam int MinutesWidth = 6;
   localparam int SecondsWidth = 6;
   localparam int OpWidth      = 2;
   localparam int ButtonCount  = 5;
   localparam int LimitWidth   = 7;
   localparam int CsrDataWidth = 32;
   localparam int CsrAddrWidth = 2;

   localparam logic [LimitWidth-1:0]   HourLimitReset = LimitWidth'(24);
   localparam logic [LimitWidth-1:0]   HourLimitMax   = LimitWidth'(99);
   localparam logic [MinutesWidth-1:0] MinuteMax      = MinutesWidth'(59);
   localparam logic [SecondsWidth-1:0] SecondMax      = SecondsWidth'(59);

   // button positions
   localparam int BtnRun     = 0;
   localparam int BtnClear   = 1;
   localparam int BtnHours   = 2;
   localparam int BtnMinutes = 3;
   localparam int BtnSeconds = 4;

   // register indexes
   localparam int RegHourLimit = 0;

   typedef enum logic [OpWidth-1:0] {
      OP_BUTTON = 2'd0,
      OP_COUNT  = 2'd1,
      OP_BLINK  = 2'd2
   } op_type;

   typedef struct packed {
      logic [HoursWidth-1:0]   hours;
      logic [MinutesWidth-1:0] minutes;
      logic [SecondsWidth-1:0] seconds;
      logic                    running;
      logic                    alarm;
      logic [ButtonCount-1:0]  press_seen;
      logic                    led_a;
      logic                    led_b;
   } timer_state_type;

endpackage

FILE: design/hms_if.sv
// ----------------------------------------------------------------------------
// hms_req_if / hms_rsp_if
// Valid/ready channels carrying timer events in and timer status out.
// ----------------------------------------------------------------------------
interface hms_req_if;
   logic                              valid;
   logic                              ready;
   logic [hms_pkg::OpWidth-1:0]       op;
   logic [hms_pkg::ButtonCount-1:0]   buttons;

   modport source (output valid, output op, output buttons, input ready);
   modport sink   (input valid, input op, input buttons, output ready);
endinterface

interface hms_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [hms_pkg::HoursWidth-1:0]    hours;
   logic [hms_pkg::MinutesWidth-1:0]  minutes;
   logic [hms_pkg::SecondsWidth-1:0]  seconds;
   logic                              running;
   logic                              alarm;
   logic                              led_a;
   logic                              led_b;

   modport source (output valid, output hours, output minutes, output seconds,
                   output running, output alarm, output led_a, output led_b,
                   input ready);
   modport sink   (input valid, input hours, input minutes, input seconds,
                   input running, input alarm, input led_a, input led_b,
                   output ready);
endinterface

FILE: design/hms_csr.sv
// ----------------------------------------------------------------------------
// hms_csr
// APB-style register port holding the hour limit.
// ----------------------------------------------------------------------------
module hms_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [hms_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [hms_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [hms_pkg::CsrDataWidth-1:0]   prdata,
   output logic                               pready,
   output logic [hms_pkg::LimitWidth-1:0]     hour_limit
);

   localparam logic [hms_pkg::CsrAddrWidth-1:0] HourLimitAddr =
      hms_pkg::CsrAddrWidth'(hms_pkg::RegHourLimit * 4);

   logic [hms_pkg::LimitWidth-1:0] limit_ff;
   logic [hms_pkg::LimitWidth-1:0] limit_in;
   logic                           wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      limit_in = limit_ff;
      if (wr_en && (paddr == HourLimitAddr)) begin
         limit_in = pwdata[hms_pkg::LimitWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= hms_pkg::HourLimitReset;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign prdata     = {{(hms_pkg::CsrDataWidth-hms_pkg::LimitWidth){1'b0}}, limit_ff};
   assign hour_limit = limit_ff;

endmodule

FILE: design/hms_step.sv
// ----------------------------------------------------------------------------
// hms_step
// Next-state logic of the timer for one event: buttons, count tick, blink tick.
// ----------------------------------------------------------------------------
module hms_step (
   input  hms_pkg::timer_state_type          cur,
   input  logic [hms_pkg::OpWidth-1:0]       op,
   input  logic [hms_pkg::ButtonCount-1:0]   buttons,
   input  logic [hms_pkg::LimitWidth-1:0]    hour_limit,
   output hms_pkg::timer_state_type          nxt
);

   logic [hms_pkg::LimitWidth-1:0]   lim;
   logic [hms_pkg::ButtonCount-1:0]  pressed;
   logic [hms_pkg::ButtonCount-1:0]  act;
   logic                             run_after;
   logic [hms_pkg::HoursWidth-1:0]   h_clr;
   logic [hms_pkg::MinutesWidth-1:0] m_clr;
   logic [hms_pkg::SecondsWidth-1:0] s_clr;
   logic [hms_pkg::HoursWidth:0]     h_inc;
   logic [hms_pkg::MinutesWidth:0]   m_inc;
   logic [hms_pkg::SecondsWidth:0]   s_inc;

   assign lim     = (hour_limit > hms_pkg::HourLimitMax) ? hms_pkg::HourLimitMax : hour_limit;
   assign pressed = ~buttons;

   // run/pause first, then set buttons only while stopped
   always_comb begin
      act                 = '0;
      act[hms_pkg::BtnRun] = pressed[hms_pkg::BtnRun] && !cur.press_seen[hms_pkg::BtnRun];
      run_after           = cur.running ^ act[hms_pkg::BtnRun];
      for (int b = 1; b < hms_pkg::ButtonCount; b++) begin
         act[b] = pressed[b] && !cur.press_seen[b] && !run_after;
      end
   end

   assign h_clr = act[hms_pkg::BtnClear] ? '0 : cur.hours;
   assign m_clr = act[hms_pkg::BtnClear] ? '0 : cur.minutes;
   assign s_clr = act[hms_pkg::BtnClear] ? '0 : cur.seconds;
   assign h_inc = {1'b0, h_clr} + (hms_pkg::HoursWidth+1)'(1);
   assign m_inc = {1'b0, m_clr} + (hms_pkg::MinutesWidth+1)'(1);
   assign s_inc = {1'b0, s_clr} + (hms_pkg::SecondsWidth+1)'(1);

   always_comb begin
      nxt = cur;
      case (op)
         hms_pkg::OP_BUTTON: begin
            if (cur.alarm) begin
               if (pressed[hms_pkg::BtnClear]) begin
                  nxt.alarm   = 1'b0;
                  nxt.running = 1'b0;
                  nxt.led_a   = 1'b0;
                  nxt.led_b   = 1'b0;
               end
            end else begin
               nxt.running    = run_after;
               nxt.press_seen = (cur.press_seen | act) & pressed;
               nxt.hours      = h_clr;
               nxt.minutes    = m_clr;
               nxt.seconds    = s_clr;
               if (act[hms_pkg::BtnHours]) begin
                  nxt.hours = (h_inc > {1'b0, lim}) ? '0 : h_inc[hms_pkg::HoursWidth-1:0];
               end
               if (act[hms_pkg::BtnMinutes]) begin
                  nxt.minutes = (m_inc > {1'b0, hms_pkg::MinuteMax}) ? '0 :
                                m_inc[hms_pkg::MinutesWidth-1:0];
               end
               if (act[hms_pkg::BtnSeconds]) begin
                  nxt.seconds = (s_inc > {1'b0, hms_pkg::SecondMax}) ? '0 :
                                s_inc[hms_pkg::SecondsWidth-1:0];
               end
            end
         end
         hms_pkg::OP_COUNT: begin
            if (cur.running && !cur.alarm) begin
               if (cur.seconds != '0) begin
                  nxt.seconds = cur.seconds - hms_pkg::SecondsWidth'(1);
               end else if (cur.minutes != '0 || cur.hours != '0) begin
                  nxt.seconds = hms_pkg::SecondMax;
                  if (cur.minutes == '0) begin
                     nxt.minutes = hms_pkg::MinuteMax;
                     nxt.hours   = cur.hours - hms_pkg::HoursWidth'(1);
                  end else begin
                     nxt.minutes = cur.minutes - hms_pkg::MinutesWidth'(1);
                  end
               end else begin
                  nxt.alarm = 1'b1;
                  nxt.led_a = 1'b1;
                  nxt.led_b = 1'b0;
               end
            end
         end
         hms_pkg::OP_BLINK: begin
            if (cur.alarm) begin
               nxt.led_a = !cur.led_a;
               nxt.led_b = !cur.led_b;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

FILE: design/hms_countdown_timer_core.sv
// ----------------------------------------------------------------------------
// hms_countdown_timer_core
// Button-set hours:minutes:seconds countdown timer with blinking alarm LEDs.
// ----------------------------------------------------------------------------
// Returns exactly one status transaction for each transaction taken, in
// order: the event is captured in an input register, then applied to the
// timer state once the response register is free or being read; the state
// doubles as the response register. The state update is one pass of short
// logic, so the sustained rate is one transaction per cycle while
// rsp_bus.ready is high. While a finished response waits for rsp_bus.ready,
// the input register takes one more transaction, then the input stalls
// until the response leaves. The hour limit is written through the APB-style
// port (register 0 at byte address 0, reset 24) while no transaction is in
// flight; the user must ensure this, as the block does not enforce it.
module hms_countdown_timer_core (
   input  logic                              clock,
   input  logic                              reset,
   hms_req_if.sink                           req_bus,
   hms_rsp_if.source                         rsp_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [hms_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [hms_pkg::CsrDataWidth-1:0]  pwdata,
   output logic [hms_pkg::CsrDataWidth-1:0]  prdata,
   output logic                              pready
);

   logic [hms_pkg::LimitWidth-1:0]   hour_limit;

   logic                             in_valid_ff;
   logic                             in_valid_in;
   logic [hms_pkg::OpWidth-1:0]      in_op_ff;
   logic [hms_pkg::ButtonCount-1:0]  in_buttons_ff;
   logic                             out_valid_ff;
   logic                             out_valid_in;
   hms_pkg::timer_state_type         state_ff;
   hms_pkg::timer_state_type         state_in;
   hms_pkg::timer_state_type         step_nxt;
   logic                             advance;
   logic                             req_take;

   hms_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .hour_limit (hour_limit)
   );

   hms_step u_step (
      .cur        (state_ff),
      .op         (in_op_ff),
      .buttons    (in_buttons_ff),
      .hour_limit (hour_limit),
      .nxt        (step_nxt)
   );

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);
      state_in     = advance ? step_nxt : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // input payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff      <= req_bus.op;
         in_buttons_ff <= req_bus.buttons;
      end
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.hours   = state_ff.hours;
   assign rsp_bus.minutes = state_ff.minutes;
   assign rsp_bus.seconds = state_ff.seconds;
   assign rsp_bus.running = state_ff.running;
   assign rsp_bus.alarm   = state_ff.alarm;
   assign rsp_bus.led_a   = state_ff.led_a;
   assign rsp_bus.led_b   = state_ff.led_b;

endmodule

FILE: design/hms_checker.sv
// ----------------------------------------------------------------------------
// hms_checker
// Port-level checks of the countdown timer core, bound to the top level.
// ----------------------------------------------------------------------------
module hms_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [hms_pkg::HoursWidth-1:0]     rsp_hours,
   input logic [hms_pkg::MinutesWidth-1:0]   rsp_minutes,
   input logic [hms_pkg::SecondsWidth-1:0]   rsp_seconds,
   input logic                               rsp_alarm,
   input logic                               rsp_led_a,
   input logic                               rsp_led_b
);

   // leds in antiphase during alarm, dark otherwise
   a_led_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alarm ? (rsp_led_a != rsp_led_b) : (!rsp_led_a && !rsp_led_b)))
      else $error("alarm led pair inconsistent");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_minutes <= hms_pkg::MinuteMax) && (rsp_seconds <= hms_pkg::SecondMax))
      else $error("minutes or seconds out of range");

   // input side stalls only behind a waiting response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without pending response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hours)
                                     && $stable(rsp_seconds) && $stable(rsp_alarm)))
      else $error("stalled response changed");

endmodule

bind hms_countdown_timer_core hms_checker u_hms_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_hours   (rsp_bus.hours),
   .rsp_minutes (rsp_bus.minutes),
   .rsp_seconds (rsp_bus.seconds),
   .rsp_alarm   (rsp_bus.alarm),
   .rsp_led_a   (rsp_bus.led_a),
   .rsp_led_b   (rsp_bus.led_b)
);

FILE: tb/hms_countdown_timer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hms_countdown_timer_core_test
// Self-checking bench for the hours:minutes:seconds countdown timer core.
// ----------------------------------------------------------------------------
// Each accepted event updates a local copy of the timer state, and the
// status it leads to is queued. Each status leaving the core is checked
// field by field against the oldest queued one. A short directed sequence
// comes first. It is followed by phases of random set/start/count-down/alarm
// episodes and random noise, with a different hour limit in each phase. Both
// channels idle and stall in random bursts except in the last phase. One long
// output stall fills the core.
module hms_countdown_timer_core_test;

   localparam logic [hms_pkg::OpWidth-1:0]     OpUnused    = 2'd3;
   localparam logic [hms_pkg::ButtonCount-1:0] AllReleased = '1;
   localparam int CycleLimit   = 400000;
   localparam int LongHold     = 300;
   localparam int PhaseCount   = 8;
   localparam int TotalEvents  = 950;
   localparam int DirectedSize = 24;
   localparam int ReportLimit  = 10;

   typedef struct packed {
      logic [hms_pkg::HoursWidth-1:0]   hours;
      logic [hms_pkg::MinutesWidth-1:0] minutes;
      logic [hms_pkg::SecondsWidth-1:0] seconds;
      logic                             running;
      logic                             alarm;
      logic                             led_a;
      logic                             led_b;
   } status_type;

   function automatic string status_text(input status_type s);
      return $sformatf("%0d:%0d:%0d running %0b alarm %0b leds %0b%0b",
                       s.hours, s.minutes, s.seconds, s.running, s.alarm, s.led_a, s.led_b);
   endfunction

   class timer_tracker;
      hms_pkg::timer_state_type       timer;
      logic [hms_pkg::LimitWidth-1:0] hour_limit;
      status_type                     expected_status[$];
      int                             mismatches;
      int                             accepted;

      function new();
         timer = '0;
         hour_limit = hms_pkg::HourLimitReset;
         mismatches = 0;
         accepted = 0;
      endfunction

      function void advance_timer(input logic [hms_pkg::OpWidth-1:0] op,
                                  input logic [hms_pkg::ButtonCount-1:0] levels);
         int lim;
         bit pressed;
         lim = (hour_limit > hms_pkg::HourLimitMax) ? int'(hms_pkg::HourLimitMax) :
                                                       int'(hour_limit);
         case (op)
            hms_pkg::OP_BUTTON: begin
               if (timer.alarm) begin
                  if (!levels[hms_pkg::BtnClear]) begin
                     timer.alarm = 1'b0;
                     timer.running = 1'b0;
                     timer.led_a = 1'b0;
                     timer.led_b = 1'b0;
                  end
               end else begin
                  for (int b = 0; b < hms_pkg::ButtonCount; b++) begin
                     pressed = !levels[b];
                     if (pressed && !timer.press_seen[b] &&
                         (b == hms_pkg::BtnRun || !timer.running)) begin
                        timer.press_seen[b] = 1'b1;
                        case (b)
                           hms_pkg::BtnRun: timer.running = !timer.running;
                           hms_pkg::BtnClear: begin
                              timer.hours = '0;
                              timer.minutes = '0;
                              timer.seconds = '0;
                           end
                           hms_pkg::BtnHours:
                              timer.hours = (int'(timer.hours) + 1 > lim) ?
                                            '0 : timer.hours + 1'b1;
                           hms_pkg::BtnMinutes:
                              timer.minutes =
                                 (int'(timer.minutes) + 1 > int'(hms_pkg::MinuteMax)) ?
                                 '0 : timer.minutes + 1'b1;
                           default:
                              timer.seconds =
                                 (int'(timer.seconds) + 1 > int'(hms_pkg::SecondMax)) ?
                                 '0 : timer.seconds + 1'b1;
                        endcase
                     end
                     if (!pressed) timer.press_seen[b] = 1'b0;
                  end
               end
            end
            hms_pkg::OP_COUNT: begin
               if (timer.running && !timer.alarm) begin
                  if (timer.seconds != 0) begin
                     timer.seconds = timer.seconds - 1'b1;
                  end else if (timer.minutes != 0 || timer.hours != 0) begin
                     timer.seconds = hms_pkg::SecondMax;
                     if (timer.minutes == 0) begin
                        timer.minutes = hms_pkg::MinuteMax;
                        timer.hours = timer.hours - 1'b1;
                     end else begin
                        timer.minutes = timer.minutes - 1'b1;
                     end
                  end else begin
                     timer.alarm = 1'b1;
                     timer.led_a = 1'b1;
                     timer.led_b = 1'b0;
                  end
               end
            end
            hms_pkg::OP_BLINK: begin
               if (timer.alarm) begin
                  timer.led_a = !timer.led_a;
                  timer.led_b = !timer.led_b;
               end
            end
            default: ;
         endcase
      endfunction

      function void note_event(input logic [hms_pkg::OpWidth-1:0] op,
                               input logic [hms_pkg::ButtonCount-1:0] levels);
         status_type s;
         advance_timer(op, levels);
         s.hours = timer.hours;
         s.minutes = timer.minutes;
         s.seconds = timer.seconds;
         s.running = timer.running;
         s.alarm = timer.alarm;
         s.led_a = timer.led_a;
         s.led_b = timer.led_b;
         expected_status.push_back(s);
         accepted++;
      endfunction

      function void check_status(input status_type got);
         status_type want;
         bit bad;
         if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportLimit)
               $display("unexpected status transaction: %s", status_text(got));
            return;
         end
         want = expected_status.pop_front();
         bad = (got.hours !== want.hours) || (got.minutes !== want.minutes) ||
               (got.seconds !== want.seconds) || (got.running !== want.running) ||
               (got.alarm !== want.alarm) || (got.led_a !== want.led_a) ||
               (got.led_b !== want.led_b);
         if (bad) begin
            mismatches++;
            if (mismatches <= ReportLimit)
               $display("status mismatch: expected %s, actual %s",
                        status_text(want), status_text(got));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel;
   logic penable;
   logic pwrite;
   logic [hms_pkg::CsrAddrWidth-1:0] paddr;
   logic [hms_pkg::CsrDataWidth-1:0] pwdata;
   logic [hms_pkg::CsrDataWidth-1:0] prdata;
   logic pready;

   hms_req_if req_bus();
   hms_rsp_if rsp_bus();

   timer_tracker tracker;
   bit idling_enabled = 1'b1;
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;
   bit hold_request = 1'b0;
   int stall_left = 0;
   int cycle_count = 0;

   hms_countdown_timer_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // status side: check, then decide on stalls for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_status('{hours: rsp_bus.hours, minutes: rsp_bus.minutes,
                                seconds: rsp_bus.seconds, running: rsp_bus.running,
                                alarm: rsp_bus.alarm, led_a: rsp_bus.led_a,
                                led_b: rsp_bus.led_b});
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         stall_left = LongHold - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (idling_enabled && $urandom_range(0, 39) == 0) rsp_quiet = !rsp_quiet;
         if (idling_enabled && !rsp_quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic logic [hms_pkg::ButtonCount-1:0] press(input int button);
      return AllReleased & ~(hms_pkg::ButtonCount'(1) << button);
   endfunction

   task automatic send_event(input logic [hms_pkg::OpWidth-1:0] op,
                             input logic [hms_pkg::ButtonCount-1:0] levels);
      if (idling_enabled && $urandom_range(0, 39) == 0) req_quiet = !req_quiet;
      if (idling_enabled && !req_quiet && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.buttons <= levels;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_event(op, levels);
   endtask

   task automatic tap(input int button);
      send_event(hms_pkg::OP_BUTTON, press(button));
      send_event(hms_pkg::OP_BUTTON, AllReleased);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (tracker.expected_status.size() != 0) @(posedge clock);
   endtask

   task automatic write_hour_limit(input logic [hms_pkg::CsrDataWidth-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= hms_pkg::CsrAddrWidth'(hms_pkg::RegHourLimit * 4);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      tracker.hour_limit = value[hms_pkg::LimitWidth-1:0];
   endtask

   task automatic random_noise();
      repeat ($urandom_range(1, 8))
         send_event(hms_pkg::OpWidth'($urandom_range(0, 3)),
                    hms_pkg::ButtonCount'($urandom_range(0, 31)));
   endtask

   // set a time, start, count down and mostly run into the alarm
   task automatic countdown_episode();
      int hour_steps;
      int minute_steps;
      int second_steps;
      int ticks;
      send_event(hms_pkg::OP_BUTTON, AllReleased);
      if (tracker.timer.alarm) tap(hms_pkg::BtnClear);
      if (tracker.timer.running) tap(hms_pkg::BtnRun);
      tap(hms_pkg::BtnClear);
      hour_steps = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      minute_steps = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      second_steps = $urandom_range(0, 6);
      if ($urandom_range(0, 15) == 0) second_steps = 61;
      if ($urandom_range(0, 23) == 0) minute_steps = 61;
      repeat (hour_steps) tap(hms_pkg::BtnHours);
      repeat (minute_steps) tap(hms_pkg::BtnMinutes);
      repeat (second_steps) tap(hms_pkg::BtnSeconds);
      tap(hms_pkg::BtnRun);
      if (tracker.timer.hours == 0 && tracker.timer.minutes == 0)
         ticks = tracker.timer.seconds + 1 + $urandom_range(0, 2);
      else
         ticks = $urandom_range(1, 40);
      repeat (ticks) begin
         if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1) == 0)
               send_event($urandom_range(0, 1) ? hms_pkg::OP_BLINK : OpUnused,
                          hms_pkg::ButtonCount'($urandom_range(0, 31)));
            else
               send_event(hms_pkg::OP_BUTTON,
                          hms_pkg::ButtonCount'($urandom_range(0, 31)) |
                          press(hms_pkg::BtnRun) ^ AllReleased ^
                          hms_pkg::ButtonCount'(1) | hms_pkg::ButtonCount'(1));
         end
         send_event(hms_pkg::OP_COUNT, hms_pkg::ButtonCount'($urandom_range(0, 31)));
      end
      if (tracker.timer.alarm) begin
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
               0: send_event(hms_pkg::OP_COUNT, hms_pkg::ButtonCount'($urandom_range(0, 31)));
               1: send_event(hms_pkg::OP_BUTTON,
                             hms_pkg::ButtonCount'($urandom_range(0, 31)) |
                             ~press(hms_pkg::BtnClear));
               2: send_event(OpUnused, hms_pkg::ButtonCount'($urandom_range(0, 31)));
               default: send_event(hms_pkg::OP_BLINK,
                                   hms_pkg::ButtonCount'($urandom_range(0, 31)));
            endcase
         end
         if ($urandom_range(0, 4) != 0)
            send_event(hms_pkg::OP_BUTTON,
                       hms_pkg::ButtonCount'($urandom_range(0, 31)) &
                       press(hms_pkg::BtnClear));
      end
   endtask

   initial begin
      logic [hms_pkg::CsrDataWidth-1:0] limit_plan [PhaseCount];
      int goal;
      tracker = new();
      limit_plan = '{32'd1, 32'd99, 32'd127, 32'd0, 32'hFFFF_FF85, 32'd2, 32'd24, 32'd0};
      limit_plan[PhaseCount-1] = $urandom;
      req_bus.valid <= 1'b0;
      req_bus.op <= hms_pkg::OP_BUTTON;
      req_bus.buttons <= AllReleased;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // ignored events, then all buttons at once while stopped
      send_event(OpUnused, '0);
      send_event(hms_pkg::OP_BLINK, AllReleased);
      send_event(hms_pkg::OP_COUNT, '0);
      send_event(hms_pkg::OP_BUTTON, '0);
      send_event(hms_pkg::OP_BUTTON, AllReleased);
      tap(hms_pkg::BtnRun);
      send_event(hms_pkg::OP_BUTTON, press(hms_pkg::BtnClear) & press(hms_pkg::BtnHours) &
                                     press(hms_pkg::BtnMinutes) & press(hms_pkg::BtnSeconds));
      send_event(hms_pkg::OP_BUTTON, AllReleased);
      send_event(hms_pkg::OP_BUTTON, press(hms_pkg::BtnClear) & press(hms_pkg::BtnHours));
      send_event(hms_pkg::OP_BUTTON, AllReleased);
      tap(hms_pkg::BtnRun);
      // hour borrow, then alarm from zero
      send_event(hms_pkg::OP_COUNT, AllReleased);
      send_event(hms_pkg::OP_BUTTON, press(hms_pkg::BtnRun));
      send_event(hms_pkg::OP_BUTTON, press(hms_pkg::BtnClear));
      send_event(hms_pkg::OP_BUTTON, press(hms_pkg::BtnRun));
      send_event(hms_pkg::OP_COUNT, AllReleased);
      send_event(hms_pkg::OP_COUNT, AllReleased);
      send_event(hms_pkg::OP_BLINK, AllReleased);
      send_event(hms_pkg::OP_BUTTON, press(hms_pkg::BtnRun));
      send_event(hms_pkg::OP_BLINK, AllReleased);
      send_event(hms_pkg::OP_BUTTON, press(hms_pkg::BtnClear));
      send_event(hms_pkg::OP_BUTTON, AllReleased);

      for (int p = 0; p < PhaseCount; p++) begin
         wait_drained();
         write_hour_limit(limit_plan[p]);
         if (p == 1) hold_request = 1'b1;
         if (p == PhaseCount - 1) idling_enabled = 1'b0;
         goal = DirectedSize + (p + 1) * TotalEvents / PhaseCount;
         while (tracker.accepted < goal) begin
            if ($urandom_range(0, 9) < 7) countdown_episode();
            else random_noise();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_status.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
